// ----- hdl/sste_pkg.sv -----
// ----------------------------------------------------------------------------
// sste_pkg
// Shared types, constants and elaboration-time helpers of the stepped sine
// tone generator: register map, configuration bundle, modular adders and the
// quarter-wave sine table.
// ----------------------------------------------------------------------------
package sste_pkg;

  localparam int unsigned ADDR_W          = 5;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned FREQ_W          = 16;
  localparam int unsigned AMP_W           = 15;
  localparam int unsigned INTERVAL_W      = 16;
  localparam int unsigned RUN_W           = 24;
  localparam int unsigned SAMPLE_W        = 16;

  localparam int unsigned QW_BITS         = 10;
  localparam int unsigned QW_SIZE         = 1 << QW_BITS;
  localparam int unsigned ROM_ADDR_W      = QW_BITS + 1;
  localparam int unsigned FULL_IDX_W      = QW_BITS + 2;

  // Largest multiple of the slowest legal rate inside a 16-bit value.
  localparam int unsigned MOD_STEPS       = 8;

  localparam int unsigned BASE_FREQ_RESET = 1000;
  localparam int unsigned AMP_RESET       = 16384;
  localparam int unsigned STEP_RESET      = 1000;
  localparam int unsigned INTERVAL_RESET  = 48000;
  localparam int unsigned RUN_RESET       = 48000;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_TERMS    = 5;
  localparam longint unsigned TAYLOR_DIV [0:TAYLOR_TERMS-1] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef enum logic [2:0] {
    REG_BASE_FREQ = 3'd0,
    REG_AMPLITUDE = 3'd1,
    REG_FREQ_STEP = 3'd2,
    REG_INTERVAL  = 3'd3,
    REG_RUN_LEN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [FREQ_W-1:0]     base_mod;
    logic [FREQ_W-1:0]     step_mod;
    logic [INTERVAL_W-1:0] interval;
    logic [RUN_W-1:0]      run_length;
    logic [AMP_W-1:0]      amplitude;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              last;
  } tone_info_t;

  typedef logic [SAMPLE_W-1:0] sine_tab_t [0:QW_SIZE];

  function automatic logic [FREQ_W-1:0] mod_rate(input logic [FREQ_W-1:0] x,
                                                 input int unsigned rate);
    logic [FREQ_W-1:0] r;
    r = x;
    for (int k = 1; k <= MOD_STEPS; k++) begin
      if (32'(x) >= 32'(k) * rate) begin
        r = FREQ_W'(32'(x) - 32'(k) * rate);
      end
    end
    return r;
  endfunction

  function automatic logic [FREQ_W-1:0] add_mod(input logic [FREQ_W-1:0] a,
                                                input logic [FREQ_W-1:0] b,
                                                input int unsigned rate);
    logic [FREQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (FREQ_W+1)'(rate)) begin
      s = s - (FREQ_W+1)'(rate);
    end
    return s[FREQ_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    for (int k = 0; k <= QW_SIZE; k++) begin
      x    = (64'(k) * PI_HALF_Q30 + 64'(QW_SIZE / 2)) >> QW_BITS;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = x;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n & 1) == 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = v[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

endpackage

// ----- hdl/stepped_sine_tone_generator.sv -----
// ----------------------------------------------------------------------------
// stepped_sine_tone_generator
// Stepped-frequency direct digital synthesis sine source.
// ----------------------------------------------------------------------------
// Each beat on the tick channel (tick_valid, tick_stall, restart) yields one
// beat on the tone channel (tone_valid, tone_stall, sample,
// current_frequency, last). restart high starts the run over at index zero,
// phase zero and the base frequency. last marks the final sample of a run;
// the following sample starts a new run by itself.
// Pipeline: a tick passes the sequencer output register, the phase-map
// registers, the table read and the output register. Throughput: one tick
// per cycle unless tone_stall holds; the accumulator add and frequency step
// are combinational; the sine table has one registered read port per sample.
// Stall: while tone_stall holds a beat, the five pipeline stages keep
// accepting ticks into empty stages; tick_stall rises once all are full.
// Reset (rst, synchronous): registers return to their defaults (1000 Hz,
// amplitude 16384, step 1000 Hz, interval 48000, run 48000), run state to
// index zero, and the pipeline empties. Registers sit on an APB port at
// 4-byte spacing; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module stepped_sine_tone_generator #(
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sste_pkg::ADDR_W-1:0]           paddr,
  input  logic [sste_pkg::DATA_W-1:0]           pwdata,
  output logic [sste_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  tick_valid,
  output logic                                  tick_stall,
  input  logic                                  restart,
  output logic                                  tone_valid,
  input  logic                                  tone_stall,
  output logic signed [sste_pkg::SAMPLE_W-1:0]  sample,
  output logic [sste_pkg::FREQ_W-1:0]           current_frequency,
  output logic                                  last
);

  sste_pkg::cfg_t                         cfg;

  logic                                   seq_valid;
  logic [sste_pkg::FREQ_W-1:0]            seq_phase;
  sste_pkg::tone_info_t                   seq_info;
  logic                                   map_ready;

  logic                                   map_valid;
  logic [sste_pkg::ROM_ADDR_W-1:0]        map_addr;
  logic                                   map_neg;
  sste_pkg::tone_info_t                   map_info;
  logic                                   scale_ready;

  sste_regs #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sste_sequencer #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (tick_valid),
    .restart    (restart),
    .in_stall   (tick_stall),
    .down_ready (map_ready),
    .out_valid  (seq_valid),
    .out_phase  (seq_phase),
    .out_info   (seq_info)
  );

  sste_phase_map #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (seq_valid),
    .in_phase   (seq_phase),
    .in_info    (seq_info),
    .up_ready   (map_ready),
    .down_ready (scale_ready),
    .out_valid  (map_valid),
    .out_addr   (map_addr),
    .out_neg    (map_neg),
    .out_info   (map_info)
  );

  sste_sine_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (map_valid),
    .in_addr           (map_addr),
    .in_neg            (map_neg),
    .in_info           (map_info),
    .amplitude         (cfg.amplitude),
    .up_ready          (scale_ready),
    .out_stall         (tone_stall),
    .out_valid         (tone_valid),
    .sample            (sample),
    .current_frequency (current_frequency),
    .last              (last)
  );

endmodule

// ----- hdl/sste_sine_rom.sv -----
// ----------------------------------------------------------------------------
// sste_sine_rom
// Quarter-wave sine table in Q1.15, 1025 entries, registered read.
// ----------------------------------------------------------------------------
module sste_sine_rom (
  input  logic                                clk,
  input  logic                                en,
  input  logic [sste_pkg::ROM_ADDR_W-1:0]     addr,
  output logic [sste_pkg::SAMPLE_W-1:0]       data
);

  localparam sste_pkg::sine_tab_t SINE_TAB = sste_pkg::build_sine_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      if (addr <= sste_pkg::ROM_ADDR_W'(sste_pkg::QW_SIZE)) begin
        data <= SINE_TAB[addr];
      end else begin
        data <= '0;
      end
    end
  end

endmodule

// ----- hdl/sste_regs.sv -----
// ----------------------------------------------------------------------------
// sste_regs
// APB register file. Keeps the written values for readback and a reduced
// copy (frequencies modulo the sample rate, interval never zero) for the
// datapath.
// ----------------------------------------------------------------------------
module sste_regs #(
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sste_pkg::ADDR_W-1:0]     paddr,
  input  logic [sste_pkg::DATA_W-1:0]     pwdata,
  output logic [sste_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output sste_pkg::cfg_t                  cfg
);

  localparam logic [sste_pkg::FREQ_W-1:0] BASE_MOD_RESET =
    sste_pkg::mod_rate(sste_pkg::FREQ_W'(sste_pkg::BASE_FREQ_RESET), SAMPLE_RATE);
  localparam logic [sste_pkg::FREQ_W-1:0] STEP_MOD_RESET =
    sste_pkg::mod_rate(sste_pkg::FREQ_W'(sste_pkg::STEP_RESET), SAMPLE_RATE);

  logic [sste_pkg::FREQ_W-1:0]     base_frequency;
  logic [sste_pkg::FREQ_W-1:0]     frequency_step;
  logic [sste_pkg::INTERVAL_W-1:0] step_interval;
  sste_pkg::reg_idx_t              idx;
  logic                            wr;

  assign pready = 1'b1;
  assign idx    = sste_pkg::reg_idx_t'(paddr[sste_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= sste_pkg::FREQ_W'(sste_pkg::BASE_FREQ_RESET);
      frequency_step <= sste_pkg::FREQ_W'(sste_pkg::STEP_RESET);
      step_interval  <= sste_pkg::INTERVAL_W'(sste_pkg::INTERVAL_RESET);
      cfg.base_mod   <= BASE_MOD_RESET;
      cfg.step_mod   <= STEP_MOD_RESET;
      cfg.interval   <= sste_pkg::INTERVAL_W'(sste_pkg::INTERVAL_RESET);
      cfg.run_length <= sste_pkg::RUN_W'(sste_pkg::RUN_RESET);
      cfg.amplitude  <= sste_pkg::AMP_W'(sste_pkg::AMP_RESET);
    end else if (wr) begin
      case (idx)
        sste_pkg::REG_BASE_FREQ: begin
          base_frequency <= pwdata[sste_pkg::FREQ_W-1:0];
          cfg.base_mod   <= sste_pkg::mod_rate(pwdata[sste_pkg::FREQ_W-1:0], SAMPLE_RATE);
        end
        sste_pkg::REG_AMPLITUDE: begin
          cfg.amplitude <= pwdata[sste_pkg::AMP_W-1:0];
        end
        sste_pkg::REG_FREQ_STEP: begin
          frequency_step <= pwdata[sste_pkg::FREQ_W-1:0];
          cfg.step_mod   <= sste_pkg::mod_rate(pwdata[sste_pkg::FREQ_W-1:0], SAMPLE_RATE);
        end
        sste_pkg::REG_INTERVAL: begin
          step_interval <= pwdata[sste_pkg::INTERVAL_W-1:0];
          if (pwdata[sste_pkg::INTERVAL_W-1:0] == '0) begin
            cfg.interval <= sste_pkg::INTERVAL_W'(1);
          end else begin
            cfg.interval <= pwdata[sste_pkg::INTERVAL_W-1:0];
          end
        end
        sste_pkg::REG_RUN_LEN: begin
          cfg.run_length <= pwdata[sste_pkg::RUN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      sste_pkg::REG_BASE_FREQ: prdata = sste_pkg::DATA_W'(base_frequency);
      sste_pkg::REG_AMPLITUDE: prdata = sste_pkg::DATA_W'(cfg.amplitude);
      sste_pkg::REG_FREQ_STEP: prdata = sste_pkg::DATA_W'(frequency_step);
      sste_pkg::REG_INTERVAL:  prdata = sste_pkg::DATA_W'(step_interval);
      sste_pkg::REG_RUN_LEN:   prdata = sste_pkg::DATA_W'(cfg.run_length);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- hdl/sste_sequencer.sv -----
// ----------------------------------------------------------------------------
// sste_sequencer
// Run state per tick: restart, frequency step at interval boundaries, phase
// accumulation modulo the sample rate, end-of-run detection.
// ----------------------------------------------------------------------------
module sste_sequencer #(
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sste_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic                          restart,
  output logic                          in_stall,
  input  logic                          down_ready,
  output logic                          out_valid,
  output logic [sste_pkg::FREQ_W-1:0]   out_phase,
  output sste_pkg::tone_info_t          out_info
);

  localparam logic [sste_pkg::FREQ_W-1:0] FREQ_RESET =
    sste_pkg::mod_rate(sste_pkg::FREQ_W'(sste_pkg::BASE_FREQ_RESET), SAMPLE_RATE);

  logic [sste_pkg::FREQ_W-1:0]     phase;
  logic [sste_pkg::FREQ_W-1:0]     frequency_now;
  logic [sste_pkg::INTERVAL_W-1:0] interval_counter;
  logic [sste_pkg::RUN_W-1:0]      run_index;

  logic [sste_pkg::FREQ_W-1:0]     phase_next;
  logic [sste_pkg::FREQ_W-1:0]     frequency_now_next;
  logic [sste_pkg::INTERVAL_W-1:0] interval_counter_next;
  logic [sste_pkg::RUN_W-1:0]      run_index_next;

  logic                            ready;
  logic                            accept;
  logic [sste_pkg::FREQ_W-1:0]     ph0;
  logic [sste_pkg::FREQ_W-1:0]     fr0;
  logic [sste_pkg::INTERVAL_W-1:0] cnt0;
  logic [sste_pkg::RUN_W-1:0]      idx0;
  logic [sste_pkg::RUN_W-1:0]      idx_inc;
  logic                            boundary;
  logic [sste_pkg::FREQ_W-1:0]     ph1;
  logic [sste_pkg::FREQ_W-1:0]     fr1;
  logic [sste_pkg::INTERVAL_W-1:0] cnt1;
  logic                            last_c;

  assign ready    = !out_valid || down_ready;
  assign accept   = in_valid && ready;
  assign in_stall = !ready;

  always_comb begin
    ph0      = restart ? '0 : phase;
    fr0      = restart ? cfg.base_mod : frequency_now;
    cnt0     = restart ? '0 : interval_counter;
    idx0     = restart ? '0 : run_index;
    boundary = cnt0 >= cfg.interval;
    fr1      = boundary ? sste_pkg::add_mod(fr0, cfg.step_mod, SAMPLE_RATE) : fr0;
    ph1      = boundary ? '0 : ph0;
    cnt1     = boundary ? '0 : cnt0;
    idx_inc  = idx0 + sste_pkg::RUN_W'(1);
    last_c   = idx_inc == cfg.run_length;
    if (last_c) begin
      phase_next            = '0;
      frequency_now_next    = cfg.base_mod;
      interval_counter_next = '0;
      run_index_next        = '0;
    end else begin
      phase_next            = sste_pkg::add_mod(ph1, fr1, SAMPLE_RATE);
      frequency_now_next    = fr1;
      interval_counter_next = (cnt1 == '1) ? cnt1 : cnt1 + sste_pkg::INTERVAL_W'(1);
      run_index_next        = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      phase            <= '0;
      frequency_now    <= FREQ_RESET;
      interval_counter <= '0;
      run_index        <= '0;
    end else begin
      if (ready) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        phase            <= phase_next;
        frequency_now    <= frequency_now_next;
        interval_counter <= interval_counter_next;
        run_index        <= run_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      out_phase     <= ph1;
      out_info.freq <= fr1;
      out_info.last <= last_c;
    end
  end

  a_state_in_range: assert property (@(posedge clk) disable iff (rst)
    phase < sste_pkg::FREQ_W'(SAMPLE_RATE) && frequency_now < sste_pkg::FREQ_W'(SAMPLE_RATE))
    else $error("phase or frequency outside the sample rate");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_c |=> run_index == '0 && phase == '0 && interval_counter == '0)
    else $error("run state not cleared after final beat");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !last_c |=> run_index == $past(idx_inc))
    else $error("run index did not advance");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(run_index) && $stable(phase))
    else $error("run state moved without an accepted beat");

endmodule

// ----- hdl/sste_phase_map.sv -----
// ----------------------------------------------------------------------------
// sste_phase_map
// Map the phase (sample-rate units) to a 4096-point cycle index, rounded
// half up, then fold it to a quarter-wave table address and a sign.
// Two stages: reciprocal multiply, then back-multiply and correct.
// ----------------------------------------------------------------------------
module sste_phase_map #(
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [sste_pkg::FREQ_W-1:0]       in_phase,
  input  sste_pkg::tone_info_t              in_info,
  output logic                              up_ready,
  input  logic                              down_ready,
  output logic                              out_valid,
  output logic [sste_pkg::ROM_ADDR_W-1:0]   out_addr,
  output logic                              out_neg,
  output sste_pkg::tone_info_t              out_info
);

  localparam int unsigned IDX_SHIFT = sste_pkg::FULL_IDX_W + 1;
  localparam int unsigned N_W       = sste_pkg::FREQ_W + IDX_SHIFT + 1;
  localparam longint unsigned DIV   = 64'(2 * SAMPLE_RATE);
  localparam int unsigned DIV_W     = $clog2(DIV + 1);
  localparam int unsigned SHIFT     = 40;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / DIV;
  localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
  localparam int unsigned Q_W       = sste_pkg::FULL_IDX_W + 1;
  localparam int unsigned T_W       = Q_W + DIV_W;
  localparam int unsigned R_W       = (T_W > N_W) ? T_W : N_W + 1;

  logic [RECIP_W-1:0]          recip_c;
  logic [DIV_W-1:0]            div_c;
  logic [N_W-1:0]              num;
  logic [N_W+RECIP_W-1:0]      prod;

  logic                        valid_b;
  logic [N_W-1:0]              num_b;
  logic [Q_W-1:0]              q_est;
  sste_pkg::tone_info_t        info_b;
  logic                        ready_b;
  logic                        ready_c;

  logic [T_W-1:0]                     back;
  logic [R_W-1:0]                     rem;
  logic [Q_W-1:0]                     q_fix;
  logic [sste_pkg::FULL_IDX_W-1:0]    p_idx;
  logic [sste_pkg::QW_BITS-1:0]       r_idx;
  logic [sste_pkg::ROM_ADDR_W-1:0]    addr_c;

  assign recip_c  = RECIP_W'(RECIP);
  assign div_c    = DIV_W'(DIV);
  assign ready_c  = !out_valid || down_ready;
  assign ready_b  = !valid_b || ready_c;
  assign up_ready = ready_b;

  always_comb begin
    num  = {1'b0, in_phase, IDX_SHIFT'(0)} + N_W'(SAMPLE_RATE);
    prod = num * recip_c;
  end

  always_comb begin
    back  = q_est * div_c;
    rem   = R_W'(num_b) - R_W'(back);
    q_fix = (rem >= R_W'(DIV)) ? q_est + Q_W'(1) : q_est;
    p_idx = q_fix[sste_pkg::FULL_IDX_W-1:0];
    r_idx = p_idx[sste_pkg::QW_BITS-1:0];
    if (p_idx[sste_pkg::QW_BITS]) begin
      addr_c = sste_pkg::ROM_ADDR_W'(sste_pkg::QW_SIZE) - {1'b0, r_idx};
    end else begin
      addr_c = {1'b0, r_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_b) begin
        valid_b <= in_valid;
      end
      if (ready_c) begin
        out_valid <= valid_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      num_b  <= num;
      q_est  <= prod[SHIFT +: Q_W];
      info_b <= in_info;
    end
    if (ready_c) begin
      out_addr <= addr_c;
      out_neg  <= p_idx[sste_pkg::FULL_IDX_W-1];
      out_info <= info_b;
    end
  end

  a_addr_in_table: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_addr <= sste_pkg::ROM_ADDR_W'(sste_pkg::QW_SIZE))
    else $error("table address beyond quarter wave");

  a_estimate_close: assert property (@(posedge clk) disable iff (rst)
    valid_b |-> rem < R_W'(2 * DIV))
    else $error("reciprocal estimate off by more than one");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    valid_b |-> q_fix <= Q_W'(1 << sste_pkg::FULL_IDX_W))
    else $error("cycle index above full cycle");

endmodule

// ----- hdl/sste_sine_scale.sv -----
// ----------------------------------------------------------------------------
// sste_sine_scale
// Table read, then scale by the amplitude, truncate toward zero, apply the
// half-wave sign and saturate. Holds the output register of the block.
// ----------------------------------------------------------------------------
module sste_sine_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [sste_pkg::ROM_ADDR_W-1:0]   in_addr,
  input  logic                              in_neg,
  input  sste_pkg::tone_info_t              in_info,
  input  logic [sste_pkg::AMP_W-1:0]        amplitude,
  output logic                              up_ready,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [sste_pkg::SAMPLE_W-1:0] sample,
  output logic [sste_pkg::FREQ_W-1:0]       current_frequency,
  output logic                              last
);

  localparam int unsigned PROD_W = sste_pkg::AMP_W + sste_pkg::SAMPLE_W;

  logic                              valid_d;
  logic                              neg_d;
  sste_pkg::tone_info_t              info_d;
  logic [sste_pkg::SAMPLE_W-1:0]     mag;
  logic                              ready_d;
  logic                              ready_e;

  logic [PROD_W-1:0]                 prod;
  logic [sste_pkg::SAMPLE_W-1:0]     scaled;
  logic [sste_pkg::SAMPLE_W:0]       clamped;
  logic [sste_pkg::SAMPLE_W-1:0]     sample_next;

  assign ready_e  = !out_valid || !out_stall;
  assign ready_d  = !valid_d || ready_e;
  assign up_ready = ready_d;

  sste_sine_rom u_rom (
    .clk  (clk),
    .en   (ready_d),
    .addr (in_addr),
    .data (mag)
  );

  always_comb begin
    prod   = amplitude * mag;
    scaled = prod[PROD_W-1 -: sste_pkg::SAMPLE_W];
    if (neg_d) begin
      clamped     = (scaled > 16'h8000) ? 17'h08000 : {1'b0, scaled};
      sample_next = sste_pkg::SAMPLE_W'((sste_pkg::SAMPLE_W+1)'(0) - clamped);
    end else begin
      clamped     = (scaled > 16'h7FFF) ? 17'h07FFF : {1'b0, scaled};
      sample_next = clamped[sste_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_d) begin
        valid_d <= in_valid;
      end
      if (ready_e) begin
        out_valid <= valid_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d) begin
      neg_d  <= in_neg;
      info_d <= in_info;
    end
    if (ready_e) begin
      sample            <= sample_next;
      current_frequency <= info_d.freq;
      last              <= info_d.last;
    end
  end

  a_sign_follows_half: assert property (@(posedge clk) disable iff (rst)
    ready_e && valid_d && !neg_d |=> !sample[sste_pkg::SAMPLE_W-1])
    else $error("positive half produced a negative sample");

  a_pipe_fills: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && !valid_d && in_valid |=> valid_d)
    else $error("table stage did not fill behind a held beat");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid_d && !out_valid |=> out_valid)
    else $error("beat lost between table and output stage");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepped sine tone generator. A directed table
// covers the reset state, the sine extremes, the end of a run, the frequency
// step at the interval boundary, a zero interval, a zero run length and
// registers above the sample rate. Random register settings and tick streams
// follow. Every tone beat is compared field by field with the table row or
// an in-bench tone predictor, while the tick side bursts and the tone side
// stalls at random, including one long stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RATE       = 48000;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned DRAIN_PAD  = 8;
  localparam int unsigned TAIL       = 16;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned DIR_ROWS   = 21;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] smp;
    logic [15:0]        freq;
    logic               lst;
  } tone_t;

  typedef struct packed {
    logic [15:0] base;
    logic [14:0] amp;
    logic [15:0] stepf;
    logic [15:0] intv;
    logic [23:0] run;
  } tone_cfg_t;

  typedef struct packed {
    logic [1:0]         cfg_sel;
    logic               rs;
    logic               typed;
    logic signed [15:0] smp;
    logic [15:0]        freq;
    logic               lst;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [sste_pkg::ADDR_W-1:0] paddr;
  logic [sste_pkg::DATA_W-1:0] pwdata;
  logic [sste_pkg::DATA_W-1:0] prdata;
  logic        pready;
  logic        tick_valid;
  logic        tick_stall;
  logic        restart;
  logic        tone_valid;
  logic        tone_stall;
  logic signed [sste_pkg::SAMPLE_W-1:0] sample;
  logic [sste_pkg::FREQ_W-1:0] current_frequency;
  logic        last;

  tone_t       pending_tones [$];
  int          mismatches;
  int          burst_left;
  bit          no_gaps;
  bit          hold_req;

  logic [15:0] quarter_sine [0:1024];
  int unsigned base_r, amp_r, step_r, intv_r, run_r;
  int unsigned ph, fnow, since_step, run_pos;

  tone_cfg_t dir_cfgs [0:3] = '{
    '{16'd1000, 15'd16384, 16'd1000, 16'd48000, 24'd48000},
    '{16'd12000, 15'd32767, 16'd0, 16'd65535, 24'd4},
    '{16'd47999, 15'd0, 16'd47999, 16'd0, 24'd0},
    '{16'd65535, 15'd32767, 16'd65535, 16'd2, 24'd16777215}
  };

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{2'd0, 1'b0, 1'b1, 16'sd0, 16'd1000, 1'b0},
    '{2'd0, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd0, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd0, 1'b1, 1'b1, 16'sd0, 16'd1000, 1'b0},
    '{2'd0, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd1, 1'b1, 1'b1, 16'sd0, 16'd12000, 1'b0},
    '{2'd1, 1'b0, 1'b1, 16'sd32766, 16'd12000, 1'b0},
    '{2'd1, 1'b0, 1'b1, 16'sd0, 16'd12000, 1'b0},
    '{2'd1, 1'b0, 1'b1, -16'sd32766, 16'd12000, 1'b1},
    '{2'd1, 1'b0, 1'b1, 16'sd0, 16'd12000, 1'b0},
    '{2'd2, 1'b1, 1'b1, 16'sd0, 16'd47999, 1'b0},
    '{2'd2, 1'b0, 1'b1, 16'sd0, 16'd47998, 1'b0},
    '{2'd2, 1'b0, 1'b1, 16'sd0, 16'd47997, 1'b0},
    '{2'd2, 1'b1, 1'b1, 16'sd0, 16'd47999, 1'b0},
    '{2'd3, 1'b1, 1'b1, 16'sd0, 16'd17535, 1'b0},
    '{2'd3, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd3, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd3, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd3, 1'b1, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd3, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0},
    '{2'd3, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0}
  };

  stepped_sine_tone_generator #(
    .SAMPLE_RATE(RATE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .restart(restart),
    .tone_valid(tone_valid),
    .tone_stall(tone_stall),
    .sample(sample),
    .current_frequency(current_frequency),
    .last(last)
  );

  always #1 clk = ~clk;

  task automatic fill_quarter_sine();
    longint unsigned ang, sq, t, acc, q;
    for (int k = 0; k <= 1024; k++) begin
      ang = (64'(k) * HALF_PI_Q30 + 64'd512) >> 10;
      sq  = (ang * ang + (64'd1 << 29)) >> 30;
      t   = ang;
      acc = ang;
      for (int n = 1; n <= 5; n++) begin
        t = ((t * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - t : acc + t;
      end
      q = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_sine[k] = (q > 64'd32767) ? 16'd32767 : q[15:0];
    end
  endtask

  function automatic void begin_run();
    ph = 0;
    fnow = base_r % RATE;
    since_step = 0;
    run_pos = 0;
  endfunction

  function automatic tone_t next_tone(input bit rs);
    int unsigned span, idx, quad, off, mag, prod;
    tone_t t;
    span = (intv_r == 0) ? 1 : intv_r;
    if (rs) begin_run();
    if (since_step >= span) begin
      fnow = (fnow + step_r % RATE) % RATE;
      ph = 0;
      since_step = 0;
    end
    t.lst = (((run_pos + 1) & 32'hFFFFFF) == run_r);
    idx = ((ph * 8192 + RATE) / (2 * RATE)) & 4095;
    quad = idx >> 10;
    off = idx & 1023;
    mag = 32'(quad[0] ? quarter_sine[1024 - off] : quarter_sine[off]);
    prod = (amp_r * mag) >> 15;
    if (quad >= 2) begin
      if (prod > 32768) prod = 32768;
      t.smp = 16'(32'd0 - prod);
    end else begin
      t.smp = (prod > 32767) ? 16'sd32767 : 16'(prod);
    end
    t.freq = 16'(fnow);
    if (t.lst) begin
      begin_run();
    end else begin
      ph = (ph + fnow) % RATE;
      if (since_step < 65535) since_step++;
      run_pos = (run_pos + 1) & 32'hFFFFFF;
    end
    return t;
  endfunction

  task automatic send_tick(input bit rs, input bit typed, input tone_t fixed);
    int gap;
    tone_t pred;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    tick_valid = 1'b1;
    restart = rs;
    do @(posedge clk); while (tick_stall);
    pred = next_tone(rs);
    pending_tones.push_back(typed ? fixed : pred);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    tick_valid = 1'b0;
    while (pending_tones.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic apb_write(input sste_pkg::reg_idx_t idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic apply_cfg(input tone_cfg_t c);
    settle();
    apb_write(sste_pkg::REG_BASE_FREQ, 32'(c.base));
    apb_write(sste_pkg::REG_AMPLITUDE, 32'(c.amp));
    apb_write(sste_pkg::REG_FREQ_STEP, 32'(c.stepf));
    apb_write(sste_pkg::REG_INTERVAL, 32'(c.intv));
    apb_write(sste_pkg::REG_RUN_LEN, 32'(c.run));
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    base_r = 32'(c.base);
    amp_r = 32'(c.amp);
    step_r = 32'(c.stepf);
    intv_r = 32'(c.intv);
    run_r = 32'(c.run);
  endtask

  function automatic tone_cfg_t draw_cfg();
    tone_cfg_t c;
    case ($urandom_range(0, 7))
      0: c.base = 16'd0;
      1: c.base = 16'd47999;
      default: c.base = 16'($urandom_range(0, 47999));
    endcase
    case ($urandom_range(0, 7))
      0: c.amp = 15'd32767;
      1: c.amp = 15'($urandom_range(0, 15));
      default: c.amp = 15'($urandom_range(0, 32767));
    endcase
    case ($urandom_range(0, 7))
      0: c.stepf = 16'd0;
      1: c.stepf = 16'd47999;
      default: c.stepf = 16'($urandom_range(0, 47999));
    endcase
    case ($urandom_range(0, 9))
      0: c.intv = 16'd65535;
      1: c.intv = 16'($urandom_range(1, 65535));
      default: c.intv = 16'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 9))
      0: c.run = 24'd16777215;
      1: c.run = 24'($urandom_range(1, 16777215));
      2: c.run = 24'd1;
      default: c.run = 24'($urandom_range(2, 80));
    endcase
    return c;
  endfunction

  always @(posedge clk) begin
    tone_t want;
    if (!rst && tone_valid === 1'b1 && tone_stall == 1'b0) begin
      if (pending_tones.size() == 0) begin
        $error("tone beat with nothing expected: sample %0d freq %0d last %0b",
               sample, current_frequency, last);
        mismatches++;
      end else begin
        want = pending_tones.pop_front();
        if (sample !== want.smp) begin
          $error("sample: expected %0d, got %0d", want.smp, sample);
          mismatches++;
        end
        if (current_frequency !== want.freq) begin
          $error("current_frequency: expected %0d, got %0d", want.freq, current_frequency);
          mismatches++;
        end
        if (last !== want.lst) begin
          $error("last: expected %0b, got %0b", want.lst, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int hold_left;
    int mode;
    int mode_left;
    bit hold_done;
    tone_stall = 1'b0;
    hold_left = 0;
    mode = 0;
    mode_left = 40;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        tone_stall = 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: tone_stall = 1'b0;
          1: tone_stall = ($urandom_range(0, 3) == 0);
          2: tone_stall = ($urandom_range(0, 9) < 6);
          default: tone_stall = mode_left[1];
        endcase
      end
    end
  end

  initial begin
    for (int c = 0; c < LIMIT; c++) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tone_t fixed;
    int cur_sel;
    int count;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_valid = 1'b0;
    restart = 1'b0;
    mismatches = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    cur_sel = 0;
    fill_quarter_sine();
    base_r = sste_pkg::BASE_FREQ_RESET;
    amp_r = sste_pkg::AMP_RESET;
    step_r = sste_pkg::STEP_RESET;
    intv_r = sste_pkg::INTERVAL_RESET;
    run_r = sste_pkg::RUN_RESET;
    begin_run();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].cfg_sel) != cur_sel) begin
        cur_sel = int'(dir_rows[i].cfg_sel);
        apply_cfg(dir_cfgs[cur_sel]);
      end
      fixed.smp = dir_rows[i].smp;
      fixed.freq = dir_rows[i].freq;
      fixed.lst = dir_rows[i].lst;
      send_tick(dir_rows[i].rs, dir_rows[i].typed, fixed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_cfg(draw_cfg());
      if (p == 2) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
      end
      count = $urandom_range(60, 90);
      repeat (count) send_tick($urandom_range(0, 15) == 0, 1'b0, fixed);
      no_gaps = 1'b0;
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
